@@ src/mmae_pkg.sv @@
// Shared constants and action codes for the memory-to-memory ALU execute unit.
// No dependencies.
package mmae_pkg;

	localparam int DATA_W    = 16;
	localparam int MEM_DEPTH = 1024;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int ACT_W     = 5;
	localparam int DIV_CNT_W = $clog2(DATA_W);

	typedef enum logic [ACT_W-1:0] {
		ACT_MOV   = 5'd0,
		ACT_LDI   = 5'd1,
		ACT_ADD   = 5'd2,
		ACT_SUB   = 5'd3,
		ACT_MUL   = 5'd4,
		ACT_DIV   = 5'd5,
		ACT_MOD   = 5'd6,
		ACT_AND   = 5'd7,
		ACT_OR    = 5'd8,
		ACT_NOT   = 5'd9,
		ACT_XOR   = 5'd10,
		ACT_SHR   = 5'd11,
		ACT_SHL   = 5'd12,
		ACT_EQ    = 5'd13,
		ACT_GT    = 5'd14,
		ACT_LT    = 5'd15,
		ACT_TEST  = 5'd16,
		ACT_READ  = 5'd17,
		ACT_WRITE = 5'd18
	} action_t;

endpackage

@@ src/mmae_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mmae_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/mmae_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on mmae_pkg.
module mmae_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [mmae_pkg::DATA_W-1:0] dividend,
	input  logic signed [mmae_pkg::DATA_W-1:0] divisor,
	output logic                              done,
	output logic signed [mmae_pkg::DATA_W-1:0] quotient,
	output logic signed [mmae_pkg::DATA_W-1:0] remainder
);

	logic                              busy_q;
	logic                              done_q;
	logic [mmae_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [mmae_pkg::DATA_W-1:0]       num_q;
	logic [mmae_pkg::DATA_W-1:0]       den_q;
	logic [mmae_pkg::DATA_W-1:0]       rem_q;
	logic                              qneg_q;
	logic                              rneg_q;

	logic [mmae_pkg::DATA_W:0]         trial;
	logic [mmae_pkg::DATA_W:0]         diff;
	logic [mmae_pkg::DATA_W-1:0]       mag_num;
	logic [mmae_pkg::DATA_W-1:0]       mag_den;
	logic                              last_bit;

	// magnitude of the most negative value wraps to itself, which is right unsigned
	assign mag_num = dividend[mmae_pkg::DATA_W-1] ? mmae_pkg::DATA_W'(-dividend) : dividend;
	assign mag_den = divisor[mmae_pkg::DATA_W-1] ? mmae_pkg::DATA_W'(-divisor) : divisor;

	assign trial    = {rem_q, num_q[mmae_pkg::DATA_W-1]};
	assign diff     = trial - {1'b0, den_q};
	assign last_bit = (cnt_q == mmae_pkg::DIV_CNT_W'(mmae_pkg::DATA_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
				num_q  <= mag_num;
				den_q  <= mag_den;
				rem_q  <= '0;
				qneg_q <= dividend[mmae_pkg::DATA_W-1] ^ divisor[mmae_pkg::DATA_W-1];
				rneg_q <= dividend[mmae_pkg::DATA_W-1];
			end else if (busy_q) begin
				if (!diff[mmae_pkg::DATA_W]) begin
					rem_q <= diff[mmae_pkg::DATA_W-1:0];
					num_q <= {num_q[mmae_pkg::DATA_W-2:0], 1'b1};
				end else begin
					rem_q <= trial[mmae_pkg::DATA_W-1:0];
					num_q <= {num_q[mmae_pkg::DATA_W-2:0], 1'b0};
				end
				cnt_q  <= cnt_q + 1'b1;
				busy_q <= !last_bit;
				done_q <= last_bit;
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// num_q holds the quotient magnitude once done
	assign done      = done_q;
	assign quotient  = qneg_q ? mmae_pkg::DATA_W'(-num_q) : num_q;
	assign remainder = rneg_q ? mmae_pkg::DATA_W'(-rem_q) : rem_q;

endmodule

@@ src/memory_to_memory_alu_execute.sv @@
// Top level of the memory-to-memory ALU execute unit.
// Depends on mmae_pkg, mmae_ram and mmae_div.
//
// Executes one request at a time against a 1024-word, 16-bit data memory held in a
// synchronous RAM with a single read port. For most actions the dest and src words
// are read one after the other on the one read port (S_RD_DEST, S_RD_SRC), then the
// ALU works in S_EXEC (multiply included), then write-back and the load of the result
// register, which raises out_valid, happen in S_DONE. Divide and modulo pass through
// S_DIV, where the iterative divider works out 16 quotient bits before S_DONE; a zero
// divisor takes the short path. A new request is taken only in S_IDLE. The result
// sits in an output register, so the next request is taken while a result waits;
// write-back happens when the result register is loaded, so the next request always
// reads the updated word.
module memory_to_memory_alu_execute (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [mmae_pkg::ACT_W-1:0]         action,
	input  logic [9:0]                         dest_addr,
	input  logic [9:0]                         src_addr,
	input  logic signed [mmae_pkg::DATA_W-1:0] imm_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [mmae_pkg::DATA_W-1:0] result_value,
	output logic                               skip_next,
	output logic                               error
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_DEST,
		S_RD_SRC,
		S_EXEC,
		S_DIV,
		S_DONE
	} state_t;

	state_t                              state_q;
	logic [mmae_pkg::ACT_W-1:0]          act_q;
	logic [mmae_pkg::ADDR_W-1:0]         dest_q;
	logic [mmae_pkg::ADDR_W-1:0]         src_q;
	logic signed [mmae_pkg::DATA_W-1:0]  imm_q;
	logic signed [mmae_pkg::DATA_W-1:0]  x_q;
	logic signed [mmae_pkg::DATA_W-1:0]  res_q;
	logic                                wr_q;
	logic                                skip_q;
	logic                                err_q;
	logic                                out_valid_q;
	logic signed [mmae_pkg::DATA_W-1:0]  out_res_q;
	logic                                out_skip_q;
	logic                                out_err_q;

	logic                                accept;
	logic                                out_free;
	logic                                load_out;
	logic                                ram_we;
	logic [mmae_pkg::ADDR_W-1:0]         ram_raddr;
	logic [mmae_pkg::DATA_W-1:0]         ram_rdata;
	logic signed [mmae_pkg::DATA_W-1:0]  y;
	logic signed [2*mmae_pkg::DATA_W-1:0] product;
	logic                                shift_bad;
	logic                                div_start;
	logic                                div_done;
	logic signed [mmae_pkg::DATA_W-1:0]  div_quot;
	logic signed [mmae_pkg::DATA_W-1:0]  div_rem;
	logic signed [mmae_pkg::DATA_W-1:0]  exec_res;
	logic                                exec_wr;
	logic                                exec_skip;
	logic                                exec_err;
	logic                                exec_div;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign load_out  = (state_q == S_DONE) && out_free;
	assign ram_we    = load_out && wr_q;
	assign ram_raddr = (state_q == S_RD_DEST) ? dest_q : src_q;

	// in S_EXEC the RAM output holds the source word
	assign y         = ram_rdata;
	assign product   = x_q * y;
	assign shift_bad = y[mmae_pkg::DATA_W-1] || (|y[mmae_pkg::DATA_W-2:5]);
	assign div_start = (state_q == S_EXEC) && exec_div;

	always_comb begin
		exec_res  = x_q;
		exec_wr   = 1'b1;
		exec_skip = 1'b0;
		exec_err  = 1'b0;
		exec_div  = 1'b0;
		unique case (act_q)
			mmae_pkg::ACT_MOV: exec_res = y;
			mmae_pkg::ACT_LDI,
			mmae_pkg::ACT_WRITE: exec_res = imm_q;
			mmae_pkg::ACT_ADD: exec_res = x_q + y;
			mmae_pkg::ACT_SUB: exec_res = x_q - y;
			mmae_pkg::ACT_MUL: exec_res = product[mmae_pkg::DATA_W-1:0];
			mmae_pkg::ACT_DIV,
			mmae_pkg::ACT_MOD: begin
				if (y == '0) begin
					exec_err = 1'b1;
					exec_wr  = 1'b0;
				end else begin
					exec_div = 1'b1;
				end
			end
			mmae_pkg::ACT_AND: exec_res = x_q & y;
			mmae_pkg::ACT_OR:  exec_res = x_q | y;
			mmae_pkg::ACT_NOT: exec_res = ~x_q;
			mmae_pkg::ACT_XOR: exec_res = x_q ^ y;
			mmae_pkg::ACT_SHR: begin
				if (shift_bad) begin
					exec_err = 1'b1;
					exec_wr  = 1'b0;
				end else begin
					exec_res = x_q >>> y[4:0];
				end
			end
			mmae_pkg::ACT_SHL: begin
				if (shift_bad) begin
					exec_err = 1'b1;
					exec_wr  = 1'b0;
				end else begin
					exec_res = x_q << y[4:0];
				end
			end
			mmae_pkg::ACT_EQ: exec_res = mmae_pkg::DATA_W'(x_q == y);
			mmae_pkg::ACT_GT: exec_res = mmae_pkg::DATA_W'(x_q > y);
			mmae_pkg::ACT_LT: exec_res = mmae_pkg::DATA_W'(x_q < y);
			mmae_pkg::ACT_TEST: begin
				exec_skip = ~x_q[0];
				exec_wr   = 1'b0;
			end
			mmae_pkg::ACT_READ: exec_wr = 1'b0;
			default: begin
				exec_res = '0;
				exec_wr  = 1'b0;
			end
		endcase
	end

	mmae_ram #(
		.WIDTH(mmae_pkg::DATA_W),
		.DEPTH(mmae_pkg::MEM_DEPTH)
	) u_data_mem (
		.clk  (clk),
		.we   (ram_we),
		.waddr(dest_q),
		.wdata(res_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	mmae_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (x_q),
		.divisor  (y),
		.done     (div_done),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q   <= action;
						// depth is a power of two: truncation is the address wrap
						dest_q  <= mmae_pkg::ADDR_W'(dest_addr);
						src_q   <= mmae_pkg::ADDR_W'(src_addr);
						imm_q   <= imm_value;
						state_q <= S_RD_DEST;
					end
				end
				S_RD_DEST: begin
					state_q <= S_RD_SRC;
				end
				S_RD_SRC: begin
					x_q     <= ram_rdata;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					res_q   <= exec_res;
					wr_q    <= exec_wr;
					skip_q  <= exec_skip;
					err_q   <= exec_err;
					state_q <= exec_div ? S_DIV : S_DONE;
				end
				S_DIV: begin
					if (div_done) begin
						res_q   <= (act_q == mmae_pkg::ACT_DIV) ? div_quot : div_rem;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_res_q  <= res_q;
						out_skip_q <= skip_q;
						out_err_q  <= err_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_res_q;
	assign skip_next    = out_skip_q;
	assign error        = out_err_q;

endmodule

@@ tb/tb_memory_to_memory_alu_execute.sv @@
// Self-checking testbench for memory_to_memory_alu_execute.
// Depends on mmae_pkg and the RTL. Runs a directed table, then random requests checked
// against a behavioral model of the data memory, with random stalls on both channels.
module tb_memory_to_memory_alu_execute;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [mmae_pkg::ACT_W-1:0] ACT_FIRST_UNUSED = 5'd19;
	localparam logic [mmae_pkg::ACT_W-1:0] ACT_LAST_CODE    = 5'd31;
	localparam int NUM_DIRECTED = 29;
	localparam int PHASE_ITEMS  = 607;
	localparam int HOLD_CYCLES  = 250;
	localparam int STALL_LIMIT  = 5000;

	typedef struct packed {
		logic [mmae_pkg::ACT_W-1:0]         act;
		logic [9:0]                         dest;
		logic [9:0]                         src;
		logic signed [mmae_pkg::DATA_W-1:0] imm;
	} instr_t;

	typedef struct packed {
		logic signed [mmae_pkg::DATA_W-1:0] value;
		logic                               skip;
		logic                               err;
	} alu_result_t;

	typedef struct packed {
		logic [mmae_pkg::ACT_W-1:0]         act;
		logic [9:0]                         dest;
		logic [9:0]                         src;
		logic signed [mmae_pkg::DATA_W-1:0] imm;
		logic                               typed;
		logic signed [mmae_pkg::DATA_W-1:0] value;
		logic                               skip;
		logic                               err;
	} dir_row_t;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_ready;
	logic [mmae_pkg::ACT_W-1:0]         action;
	logic [9:0]                         dest_addr;
	logic [9:0]                         src_addr;
	logic signed [mmae_pkg::DATA_W-1:0] imm_value;
	logic                               out_valid;
	logic                               out_ready;
	logic signed [mmae_pkg::DATA_W-1:0] result_value;
	logic                               skip_next;
	logic                               error;

	// model of the data memory and which words hold a defined value
	logic signed [mmae_pkg::DATA_W-1:0] model_mem [mmae_pkg::MEM_DEPTH];
	bit                                 is_written [mmae_pkg::MEM_DEPTH];
	int                                 written_addrs [$];

	alu_result_t pending_results [$];
	int          fail_count = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_left = 0;
	int          stall_cycles = 0;

	// expected values typed in only where they follow directly from the action
	dir_row_t directed_rows [NUM_DIRECTED] = '{
		'{mmae_pkg::ACT_WRITE, 10'd0,    10'd0, 16'sh8000, 1'b1, 16'sh8000, 1'b0, 1'b0},
		'{mmae_pkg::ACT_LDI,   10'd1023, 10'd0, 16'sh7fff, 1'b1, 16'sh7fff, 1'b0, 1'b0},
		'{mmae_pkg::ACT_LDI,   10'd1,    10'd0, 16'shffff, 1'b1, 16'shffff, 1'b0, 1'b0},
		'{mmae_pkg::ACT_LDI,   10'd2,    10'd0, 16'sh0000, 1'b1, 16'sh0000, 1'b0, 1'b0},
		'{mmae_pkg::ACT_MOV,   10'd3,    10'd0, 16'sh0000, 1'b1, 16'sh8000, 1'b0, 1'b0},
		'{mmae_pkg::ACT_DIV,   10'd3,    10'd1, 16'sh0000, 1'b1, 16'sh8000, 1'b0, 1'b0},
		'{mmae_pkg::ACT_MOD,   10'd3,    10'd1, 16'sh0000, 1'b1, 16'sh0000, 1'b0, 1'b0},
		'{mmae_pkg::ACT_DIV,   10'd1023, 10'd2, 16'sh0000, 1'b1, 16'sh7fff, 1'b0, 1'b1},
		'{mmae_pkg::ACT_MOD,   10'd0,    10'd2, 16'sh0000, 1'b1, 16'sh8000, 1'b0, 1'b1},
		'{mmae_pkg::ACT_LDI,   10'd5,    10'd0, 16'sd40,   1'b1, 16'sd40,   1'b0, 1'b0},
		'{mmae_pkg::ACT_SHL,   10'd1023, 10'd5, 16'sh0000, 1'b1, 16'sh7fff, 1'b0, 1'b1},
		'{mmae_pkg::ACT_SHR,   10'd0,    10'd1, 16'sh0000, 1'b1, 16'sh8000, 1'b0, 1'b1},
		'{mmae_pkg::ACT_LDI,   10'd6,    10'd0, 16'sd20,   1'b1, 16'sd20,   1'b0, 1'b0},
		'{mmae_pkg::ACT_SHR,   10'd0,    10'd6, 16'sh0000, 1'b1, 16'shffff, 1'b0, 1'b0},
		'{mmae_pkg::ACT_SHL,   10'd1023, 10'd6, 16'sh0000, 1'b1, 16'sh0000, 1'b0, 1'b0},
		'{mmae_pkg::ACT_TEST,  10'd3,    10'd0, 16'sh0000, 1'b1, 16'sh0000, 1'b1, 1'b0},
		'{mmae_pkg::ACT_TEST,  10'd0,    10'd0, 16'sh0000, 1'b1, 16'shffff, 1'b0, 1'b0},
		'{mmae_pkg::ACT_READ,  10'd5,    10'd0, 16'sh0000, 1'b1, 16'sd40,   1'b0, 1'b0},
		'{ACT_LAST_CODE,       10'd5,    10'd6, 16'sh5a5a, 1'b1, 16'sh0000, 1'b0, 1'b0},
		'{mmae_pkg::ACT_ADD,   10'd6,    10'd5, 16'sh0000, 1'b0, 16'sh0000, 1'b0, 1'b0},
		'{mmae_pkg::ACT_SUB,   10'd6,    10'd1, 16'sh0000, 1'b0, 16'sh0000, 1'b0, 1'b0},
		'{mmae_pkg::ACT_MUL,   10'd6,    10'd6, 16'sh0000, 1'b0, 16'sh0000, 1'b0, 1'b0},
		'{mmae_pkg::ACT_AND,   10'd6,    10'd5, 16'sh0000, 1'b0, 16'sh0000, 1'b0, 1'b0},
		'{mmae_pkg::ACT_OR,    10'd6,    10'd3, 16'sh0000, 1'b0, 16'sh0000, 1'b0, 1'b0},
		'{mmae_pkg::ACT_XOR,   10'd6,    10'd5, 16'sh0000, 1'b0, 16'sh0000, 1'b0, 1'b0},
		'{mmae_pkg::ACT_NOT,   10'd6,    10'd0, 16'sh0000, 1'b0, 16'sh0000, 1'b0, 1'b0},
		'{mmae_pkg::ACT_EQ,    10'd5,    10'd5, 16'sh0000, 1'b0, 16'sh0000, 1'b0, 1'b0},
		'{mmae_pkg::ACT_GT,    10'd6,    10'd5, 16'sh0000, 1'b0, 16'sh0000, 1'b0, 1'b0},
		'{mmae_pkg::ACT_LT,    10'd1,    10'd5, 16'sh0000, 1'b0, 16'sh0000, 1'b0, 1'b0}
	};

	memory_to_memory_alu_execute dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.dest_addr    (dest_addr),
		.src_addr     (src_addr),
		.imm_value    (imm_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.skip_next    (skip_next),
		.error        (error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one action to the memory model and returns the result it reports.
	function automatic alu_result_t execute_action(instr_t ins);
		int          x;
		int          y;
		int          r;
		bit          wr;
		alu_result_t res;
		x = model_mem[ins.dest];
		y = model_mem[ins.src];
		r = x;
		wr = 1'b1;
		res.skip = 1'b0;
		res.err = 1'b0;
		case (ins.act)
			mmae_pkg::ACT_MOV:   r = y;
			mmae_pkg::ACT_LDI,
			mmae_pkg::ACT_WRITE: r = ins.imm;
			mmae_pkg::ACT_ADD:   r = x + y;
			mmae_pkg::ACT_SUB:   r = x - y;
			mmae_pkg::ACT_MUL:   r = x * y;
			mmae_pkg::ACT_DIV,
			mmae_pkg::ACT_MOD: begin
				if (y == 0) begin
					res.err = 1'b1;
					wr = 1'b0;
				end else begin
					r = (ins.act == mmae_pkg::ACT_DIV) ? x / y : x % y;
				end
			end
			mmae_pkg::ACT_AND:   r = x & y;
			mmae_pkg::ACT_OR:    r = x | y;
			mmae_pkg::ACT_NOT:   r = ~x;
			mmae_pkg::ACT_XOR:   r = x ^ y;
			mmae_pkg::ACT_SHR,
			mmae_pkg::ACT_SHL: begin
				if (y < 0 || y > 31) begin
					res.err = 1'b1;
					wr = 1'b0;
				end else begin
					r = (ins.act == mmae_pkg::ACT_SHR) ? x >>> y : x << y;
				end
			end
			mmae_pkg::ACT_EQ:    r = (x == y) ? 1 : 0;
			mmae_pkg::ACT_GT:    r = (x > y) ? 1 : 0;
			mmae_pkg::ACT_LT:    r = (x < y) ? 1 : 0;
			mmae_pkg::ACT_TEST: begin
				res.skip = ~x[0];
				wr = 1'b0;
			end
			mmae_pkg::ACT_READ:  wr = 1'b0;
			default: begin
				r = 0;
				wr = 1'b0;
			end
		endcase
		if (wr)
			model_mem[ins.dest] = r[mmae_pkg::DATA_W-1:0];
		res.value = r[mmae_pkg::DATA_W-1:0];
		return res;
	endfunction

	function automatic logic signed [mmae_pkg::DATA_W-1:0] pick_imm();
		logic signed [mmae_pkg::DATA_W-1:0] extremes [5] = '{16'sh8000, 16'sh7fff,
			16'sh0000, 16'shffff, 16'sh0001};
		case ($urandom_range(0, 5))
			0:       return $signed(16'($urandom_range(0, 80))) - 16'sd40;
			1:       return extremes[$urandom_range(0, 4)];
			2:       return 16'($urandom_range(0, 31));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [9:0] pick_written();
		return 10'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
	endfunction

	// Operands other than a fresh destination always come from defined words.
	function automatic instr_t random_instr();
		instr_t ins;
		int     sel;
		sel = $urandom_range(0, 99);
		ins.imm = pick_imm();
		ins.src = pick_written();
		ins.dest = pick_written();
		if (sel < 10) begin
			ins.act = mmae_pkg::ACT_LDI;
			ins.dest = 10'($urandom_range(0, mmae_pkg::MEM_DEPTH - 1));
		end else if (sel < 16) begin
			ins.act = mmae_pkg::ACT_WRITE;
			ins.dest = 10'($urandom_range(0, mmae_pkg::MEM_DEPTH - 1));
		end else if (sel < 20) begin
			ins.act = mmae_pkg::ACT_MOV;
			ins.dest = 10'($urandom_range(0, mmae_pkg::MEM_DEPTH - 1));
		end else if (sel < 23) begin
			ins.act = mmae_pkg::ACT_W'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_CODE));
			ins.imm = 16'($urandom);
		end else if (sel < 30) begin
			// refill written words with small values so zero divisors and legal shifts recur
			ins.act = mmae_pkg::ACT_LDI;
			ins.imm = 16'($urandom_range(0, 40)) - 16'sd8;
		end else begin
			ins.act = mmae_pkg::ACT_W'($urandom_range(mmae_pkg::ACT_MOV, mmae_pkg::ACT_READ));
		end
		return ins;
	endfunction

	// Caller returns right after a rising edge; the request is driven at a falling edge, after any random idle gaps.
	task automatic send_request(instr_t ins, bit typed, alu_result_t typed_res);
		alu_result_t res;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		action    <= ins.act;
		dest_addr <= ins.dest;
		src_addr  <= ins.src;
		imm_value <= ins.imm;
		do
			@(posedge clk);
		while (!in_ready);
		res = execute_action(ins);
		pending_results = {pending_results, (typed ? typed_res : res)};
		if ((ins.act == mmae_pkg::ACT_LDI || ins.act == mmae_pkg::ACT_WRITE
				|| ins.act == mmae_pkg::ACT_MOV) && !is_written[ins.dest]) begin
			is_written[ins.dest] = 1'b1;
			written_addrs = {written_addrs, int'(ins.dest)};
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random back-pressure, plus a long hold-off when asked
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : check_results
		alu_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: value %h skip %b error %b", $time,
					result_value, skip_next, error);
				fail_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (result_value !== exp_res.value) begin
					$display("%0t: result_value mismatch: expected %h actual %h", $time,
						exp_res.value, result_value);
					fail_count++;
				end
				if (skip_next !== exp_res.skip) begin
					$display("%0t: skip_next mismatch: expected %b actual %b", $time,
						exp_res.skip, skip_next);
					fail_count++;
				end
				if (error !== exp_res.err) begin
					$display("%0t: error mismatch: expected %b actual %b", $time,
						exp_res.err, error);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("memory_to_memory_alu_execute test failed");
			$finish;
		end
	end

	initial begin
		instr_t      ins;
		alu_result_t res;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		action    = '0;
		dest_addr = '0;
		src_addr  = '0;
		imm_value = '0;
		out_ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		send_idle_pct = 17;
		recv_idle_pct = 84;
		foreach (directed_rows[i]) begin
			ins = '{directed_rows[i].act, directed_rows[i].dest, directed_rows[i].src,
				directed_rows[i].imm};
			res = '{directed_rows[i].value, directed_rows[i].skip, directed_rows[i].err};
			send_request(ins, directed_rows[i].typed, res);
		end
		repeat (PHASE_ITEMS)
			send_request(random_instr(), 1'b0, '0);

		// sender pauses until the block is empty
		drain_results();

		send_idle_pct = 84;
		recv_idle_pct = 17;
		repeat (PHASE_ITEMS)
			send_request(random_instr(), 1'b0, '0);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		// long receiver hold-off while requests keep coming, so the input stalls
		hold_left = HOLD_CYCLES;
		repeat (PHASE_ITEMS)
			send_request(random_instr(), 1'b0, '0);

		drain_results();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("memory_to_memory_alu_execute test passed");
		else
			$display("memory_to_memory_alu_execute test failed");
		$finish;
	end

endmodule

@@ files.f @@
src/mmae_pkg.sv
src/mmae_ram.sv
src/mmae_div.sv
src/memory_to_memory_alu_execute.sv
tb/tb_memory_to_memory_alu_execute.sv
